### design/rvx_pkg.sv
`default_nettype none
package rvx_pkg;

	// opcodes
	localparam logic [3:0] OP_ADD   = 4'd0;
	localparam logic [3:0] OP_SUB   = 4'd1;
	localparam logic [3:0] OP_SHL   = 4'd2;
	localparam logic [3:0] OP_ASHR  = 4'd3;
	localparam logic [3:0] OP_LSHR  = 4'd4;
	localparam logic [3:0] OP_AND   = 4'd5;
	localparam logic [3:0] OP_OR    = 4'd6;
	localparam logic [3:0] OP_NOT   = 4'd7;
	localparam logic [3:0] OP_ST    = 4'd8;
	localparam logic [3:0] OP_LD    = 4'd9;
	localparam logic [3:0] OP_STACK = 4'd10;
	localparam logic [3:0] OP_LOCS  = 4'd11;
	localparam logic [3:0] OP_CMP   = 4'd12;
	localparam logic [3:0] OP_BR    = 4'd13;
	localparam logic [3:0] OP_TRAP  = 4'd14;

	// source modes
	localparam logic [1:0] MODE_REG  = 2'd0;
	localparam logic [1:0] MODE_IMM  = 2'd1;
	localparam logic [1:0] MODE_BASE = 2'd2;
	localparam logic [1:0] MODE_IND  = 2'd3;

	// branch kinds
	localparam logic [2:0] BK_JMP = 3'd0;
	localparam logic [2:0] BK_JEQ = 3'd1;
	localparam logic [2:0] BK_JGT = 3'd2;
	localparam logic [2:0] BK_JLT = 3'd3;
	localparam logic [2:0] BK_JGE = 3'd4;
	localparam logic [2:0] BK_JLE = 3'd5;
	localparam logic [2:0] BK_JSR = 3'd6;
	localparam logic [2:0] BK_RET = 3'd7;

	// status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_HALT  = 3'd1;
	localparam logic [2:0] ST_SOVF  = 3'd2;
	localparam logic [2:0] ST_SUNF  = 3'd3;
	localparam logic [2:0] ST_ILL   = 3'd4;
	localparam logic [2:0] ST_BOVF  = 3'd5;

	// trap codes with a meaning of their own
	localparam logic [15:0] TRAP_HALT = 16'd0;
	localparam logic [15:0] TRAP_DUMP = 16'd1;

	// register file request
	typedef struct packed {
		logic        we;
		logic [2:0]  waddr;
		logic [15:0] wdata;
		logic [2:0]  raddr_a;
		logic [2:0]  raddr_b;
	} rf_req_t;

	// byte memory request, address bits above the depth are dropped
	typedef struct packed {
		logic        we;
		logic [15:0] waddr;
		logic [7:0]  wdata;
		logic [15:0] raddr0;
		logic [15:0] raddr1;
	} mem_req_t;

	// one result
	typedef struct packed {
		logic [15:0] next_pc;
		logic [3:0]  flag_bits;
		logic [2:0]  status;
		logic [15:0] trap_code;
		logic        trap_user;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

### design/rvx_regfile.sv
`default_nettype none
module rvx_regfile
	import rvx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rf_req_t     req,
	output logic [15:0]      rdata_a,
	output logic [15:0]      rdata_b
);

	logic [15:0] mem [8];
	logic [7:0]  valid_q;

	// storage write
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// valid bits, an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.we) begin
			valid_q[req.waddr] <= 1'b1;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= valid_q[req.raddr_a] ? mem[req.raddr_a] : 16'd0;
		rdata_b <= valid_q[req.raddr_b] ? mem[req.raddr_b] : 16'd0;
	end

endmodule
`default_nettype wire

### design/rvx_bytemem.sv
`default_nettype none
module rvx_bytemem
	import rvx_pkg::*;
#(
	parameter int DEPTH = 65536
)(
	input  wire logic        clk,
	input  wire mem_req_t    req,
	output logic [7:0]       rdata0,
	output logic [7:0]       rdata1
);

	localparam int AW = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		rdata0 <= mem[req.raddr0[AW-1:0]];
		rdata1 <= mem[req.raddr1[AW-1:0]];
	end

endmodule
`default_nettype wire

### design/register_vm_execute_unit.sv
`default_nettype none
// Execute unit of a small register machine.
// A request is one decoded instruction, taken at a clock edge with start high
// and busy low. Results come back on the result ports, each for exactly one
// cycle with done high; last marks the final result of a request. A dump trap
// gives eight results, everything else one. The receiver cannot stall.
// A plain ALU, compare, branch, locs or load request ends in the execute
// state; a store or jsr then writes its two bytes in the low and high write
// states, a base-slot or indirect access first reads a word in the read and
// data states, ret reads two stack words, and push and pop step through the
// eight mask bits. A request to a halted unit is answered in the next cycle.
// The byte memories write one byte per cycle and read a word at once.
// cfg_wr_en/cfg_wr_data load the program counter; the user must write it only
// while idle; the block does not enforce this. After reset busy stays
// high while both memories are cleared, one byte per cycle; configuration
// writes are taken meanwhile. Registers, flags, pointers and halt reset to zero.
module register_vm_execute_unit
	import rvx_pkg::*;
#(
	parameter int MEM_BYTES   = 65536,
	parameter int STACK_BYTES = 65536
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  op,
	input  wire logic [1:0]  src_mode,
	input  wire logic [2:0]  dst_reg,
	input  wire logic [2:0]  src_reg,
	input  wire logic [15:0] imm,
	input  wire logic [2:0]  branch_kind,
	input  wire logic        push_or_user,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	output logic             done,
	output logic [15:0]      next_pc,
	output logic [3:0]       flag_bits,
	output logic [2:0]       status,
	output logic [15:0]      trap_code,
	output logic             trap_user,
	output logic [2:0]       reg_index,
	output logic [15:0]      reg_value,
	output logic             last
);

	localparam logic [16:0] MEM_SZ = 17'(MEM_BYTES);
	localparam logic [16:0] STK_SZ = 17'(STACK_BYTES);
	localparam int CLR_N = (MEM_BYTES > STACK_BYTES) ? MEM_BYTES : STACK_BYTES;
	localparam int CW    = $clog2(CLR_N);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_EXEC  = 4'd2;
	localparam logic [3:0] S_SRD   = 4'd3;
	localparam logic [3:0] S_SDAT  = 4'd4;
	localparam logic [3:0] S_DRD   = 4'd5;
	localparam logic [3:0] S_DDAT  = 4'd6;
	localparam logic [3:0] S_WLO   = 4'd7;
	localparam logic [3:0] S_WHI   = 4'd8;
	localparam logic [3:0] S_PSEL  = 4'd9;
	localparam logic [3:0] S_PRD   = 4'd10;
	localparam logic [3:0] S_QSEL  = 4'd11;
	localparam logic [3:0] S_DRQ   = 4'd12;
	localparam logic [3:0] S_DEM   = 4'd13;

	// reduce a 16-bit address modulo a depth of at least 256 bytes:
	// the quotient then has at most eight bits
	function automatic logic [15:0] wrap_mod(input logic [15:0] a, input logic [16:0] size);
		logic [23:0] t;
		logic [15:0] r;
		r = a;
		for (int k = 7; k >= 0; k--) begin
			t = {7'd0, size} << k;
			if ({8'd0, r} >= t) r = r - t[15:0];
		end
		return r;
	endfunction

	// next byte address with wrap at the depth
	function automatic logic [15:0] inc_wrap(input logic [15:0] idx, input logic [16:0] size);
		logic [16:0] s;
		s = {1'b0, idx} + 17'd1;
		return (s == size) ? 16'd0 : s[15:0];
	endfunction

	logic [3:0]  state_q;
	logic [CW-1:0] clr_q;
	logic [3:0]  op_q;
	logic [1:0]  mode_q;
	logic [2:0]  dst_q;
	logic [15:0] imm_q;
	logic [2:0]  bk_q;
	logic        pu_q;
	logic [15:0] pc_q, sp_q, bp_q;
	logic [3:0]  flags_q;
	logic        halted_q;
	logic [3:0]  bit_q;
	logic        phase_q;
	logic [15:0] ra_q, ra2_q, wa_q, wv_q, dest_q, tmp_q;
	logic        wsel_stk_q;
	logic        done_q;
	res_t        res_q;

	rf_req_t     rf_req;
	mem_req_t    dm_req, sm_req;
	logic [15:0] rf_a, rf_b;
	logic [7:0]  dm_rd0, dm_rd1, sm_rd0, sm_rd1;

	rvx_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (rf_req),
		.rdata_a (rf_a),
		.rdata_b (rf_b)
	);

	rvx_bytemem #(.DEPTH(MEM_BYTES)) u_dmem (
		.clk    (clk),
		.req    (dm_req),
		.rdata0 (dm_rd0),
		.rdata1 (dm_rd1)
	);

	rvx_bytemem #(.DEPTH(STACK_BYTES)) u_smem (
		.clk    (clk),
		.req    (sm_req),
		.rdata0 (sm_rd0),
		.rdata1 (sm_rd1)
	);

	logic        accept;
	logic [15:0] pc_plus2, target, opnd, s_word, d_word;
	logic [15:0] alu_res;
	logic [3:0]  alu_flags;
	logic        alu_wr, alu_setf;
	logic [16:0] sum17;
	logic [16:0] shl17;
	logic [17:0] base_addr;
	logic [3:0]  n_bits, pop_cnt;
	logic        base_bad, push_bad, pop_bad, locs_bad, jsr_bad, ret_bad, take;
	logic        fz, fn, fv;
	res_t        ok_res;

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign pc_plus2 = pc_q + 16'd2;
	assign target   = pc_q + {imm_q[14:0], 1'b0};
	assign opnd     = (mode_q == MODE_REG) ? rf_b : imm_q;
	assign s_word   = {sm_rd1, sm_rd0};
	assign d_word   = {dm_rd1, dm_rd0};
	assign fz       = flags_q[0];
	assign fn       = flags_q[1];
	assign fv       = flags_q[3];

	// limit checks
	assign n_bits    = 4'($countones(imm_q[7:0]));
	assign pop_cnt   = (imm_q == 16'd0) ? 4'd1 : n_bits;
	assign base_addr = {2'b0, bp_q} + {1'b0, imm_q, 1'b0};
	assign base_bad  = base_addr > {2'b0, sp_q};
	assign push_bad  = (n_bits != 4'd0)
		&& (({2'b0, sp_q} + {13'd0, n_bits - 4'd1, 1'b0}) > ({1'b0, STK_SZ} - 18'd3));
	assign pop_bad   = {1'b0, sp_q} < {12'd0, pop_cnt, 1'b0};
	assign locs_bad  = ({1'b0, sp_q} + {1'b0, imm_q}) > (STK_SZ - 17'd1);
	assign jsr_bad   = {1'b0, sp_q} > (STK_SZ - 17'd3);
	assign ret_bad   = bp_q < 16'd4;

	// branch condition
	always_comb begin
		case (bk_q)
			BK_JMP:  take = 1'b1;
			BK_JEQ:  take = fz;
			BK_JGT:  take = !fz && (fn == fv);
			BK_JLT:  take = fn != fv;
			BK_JGE:  take = fn == fv;
			BK_JLE:  take = fz || (fn != fv);
			default: take = 1'b0;
		endcase
	end

	// alu on the register read data
	always_comb begin
		sum17     = {1'b0, rf_a} + {1'b0, opnd};
		shl17     = (imm_q > 16'd16) ? 17'd0 : ({1'b0, rf_a} << imm_q[4:0]);
		alu_res   = rf_a;
		alu_flags = flags_q;
		alu_wr    = 1'b0;
		alu_setf  = 1'b0;
		case (op_q)
			OP_ADD: begin
				alu_res   = sum17[15:0];
				alu_flags = {(~(rf_a ^ opnd) & (rf_a ^ sum17[15:0]) & 16'h8000) != 16'd0,
					sum17[16], sum17[15], sum17[15:0] == 16'd0};
				alu_wr    = 1'b1;
				alu_setf  = 1'b1;
			end
			OP_SUB, OP_CMP: begin
				alu_res   = rf_a - opnd;
				alu_flags = {((rf_a ^ opnd) & (rf_a ^ alu_res) & 16'h8000) != 16'd0,
					rf_a < opnd, alu_res[15], alu_res == 16'd0};
				alu_wr    = (op_q == OP_SUB);
				alu_setf  = 1'b1;
			end
			OP_SHL: begin
				alu_res   = shl17[15:0];
				alu_flags = {1'b0, shl17[16], shl17[15], shl17[15:0] == 16'd0};
				alu_wr    = 1'b1;
				alu_setf  = 1'b1;
			end
			OP_ASHR: begin
				alu_res = (imm_q >= 16'd16) ? {16{rf_a[15]}} : 16'($signed(rf_a) >>> imm_q[3:0]);
				alu_wr  = 1'b1;
			end
			OP_LSHR: begin
				alu_res = (imm_q >= 16'd16) ? 16'd0 : (rf_a >> imm_q[3:0]);
				alu_wr  = 1'b1;
			end
			OP_AND: begin
				alu_res = rf_a & opnd;
				alu_wr  = 1'b1;
			end
			OP_OR: begin
				alu_res = rf_a | opnd;
				alu_wr  = 1'b1;
			end
			OP_NOT: begin
				alu_res = ~rf_a;
				alu_wr  = 1'b1;
			end
			default: begin
				alu_res = rf_a;
			end
		endcase
	end

	// plain completion result
	always_comb begin
		ok_res           = '0;
		ok_res.next_pc   = pc_plus2;
		ok_res.flag_bits = flags_q;
		ok_res.status    = ST_OK;
		ok_res.last      = 1'b1;
	end

	// register file port
	always_comb begin
		rf_req         = '0;
		rf_req.raddr_a = (state_q == S_IDLE) ? dst_reg : bit_q[2:0];
		rf_req.raddr_b = src_reg;
		case (state_q)
			S_EXEC: begin
				rf_req.waddr = dst_q;
				if (op_q == OP_LD) begin
					rf_req.we    = (mode_q == MODE_REG) || (mode_q == MODE_IMM);
					rf_req.wdata = (mode_q == MODE_REG) ? rf_b : imm_q;
				end else begin
					rf_req.we    = alu_wr && (op_q <= OP_NOT);
					rf_req.wdata = alu_res;
				end
			end
			S_SDAT: begin
				rf_req.we    = (op_q == OP_LD) || (op_q == OP_STACK);
				rf_req.waddr = (op_q == OP_STACK) ? bit_q[2:0] : dst_q;
				rf_req.wdata = s_word;
			end
			S_DDAT: begin
				rf_req.we    = 1'b1;
				rf_req.waddr = dst_q;
				rf_req.wdata = d_word;
			end
			default: begin
				rf_req.we = 1'b0;
			end
		endcase
	end

	// memory ports: clearing pass, then byte writes and word reads
	always_comb begin
		dm_req        = '0;
		sm_req        = '0;
		dm_req.raddr0 = ra_q;
		dm_req.raddr1 = inc_wrap(ra_q, MEM_SZ);
		sm_req.raddr0 = ra_q;
		sm_req.raddr1 = inc_wrap(ra_q, STK_SZ);
		if (state_q == S_CLEAR) begin
			dm_req.we    = 17'(clr_q) < MEM_SZ;
			dm_req.waddr = 16'(clr_q);
			sm_req.we    = 17'(clr_q) < STK_SZ;
			sm_req.waddr = 16'(clr_q);
		end else if (state_q == S_WLO || state_q == S_WHI) begin
			dm_req.we    = !wsel_stk_q;
			sm_req.we    = wsel_stk_q;
			dm_req.waddr = (state_q == S_WLO) ? wa_q : inc_wrap(wa_q, MEM_SZ);
			sm_req.waddr = (state_q == S_WLO) ? wa_q : inc_wrap(wa_q, STK_SZ);
			dm_req.wdata = (state_q == S_WLO) ? wv_q[7:0] : wv_q[15:8];
			sm_req.wdata = dm_req.wdata;
		end
	end

	// request fields
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			mode_q <= src_mode;
			dst_q  <= dst_reg;
			imm_q  <= imm;
			bk_q   <= branch_kind;
			pu_q   <= push_or_user;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			pc_q       <= '0;
			sp_q       <= '0;
			bp_q       <= '0;
			flags_q    <= '0;
			halted_q   <= 1'b0;
			bit_q      <= '0;
			phase_q    <= 1'b0;
			done_q     <= 1'b0;
			wsel_stk_q <= 1'b0;
			ra_q       <= '0;
			ra2_q      <= '0;
			wa_q       <= '0;
			wv_q       <= '0;
			dest_q     <= '0;
			tmp_q      <= '0;
			res_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CLR_N - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (halted_q) begin
							res_q           <= '0;
							res_q.next_pc   <= pc_q;
							res_q.flag_bits <= flags_q;
							res_q.status    <= ST_HALT;
							res_q.last      <= 1'b1;
							done_q          <= 1'b1;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					bit_q   <= '0;
					phase_q <= 1'b0;
					state_q <= S_IDLE;
					res_q   <= ok_res;
					done_q  <= 1'b1;
					pc_q    <= pc_plus2;
					dest_q  <= wrap_mod(rf_a, MEM_SZ);
					case (op_q)
						OP_ST, OP_LD: begin
							if (mode_q == MODE_BASE && base_bad) begin
								halted_q     <= 1'b1;
								pc_q         <= pc_q;
								res_q.next_pc <= pc_q;
								res_q.status <= ST_ILL;
							end else if (mode_q == MODE_BASE) begin
								ra_q    <= wrap_mod(base_addr[15:0], STK_SZ);
								state_q <= S_SRD;
								done_q  <= 1'b0;
								pc_q    <= pc_q;
							end else if (op_q == OP_LD && mode_q == MODE_IND) begin
								ra_q    <= wrap_mod(rf_b, MEM_SZ);
								state_q <= S_DRD;
								done_q  <= 1'b0;
								pc_q    <= pc_q;
							end else if (op_q == OP_ST) begin
								wv_q       <= (mode_q == MODE_IMM) ? imm_q : rf_b;
								wa_q       <= wrap_mod(rf_a, MEM_SZ);
								wsel_stk_q <= 1'b0;
								state_q    <= S_WLO;
								done_q     <= 1'b0;
								pc_q       <= pc_q;
							end
						end
						OP_STACK: begin
							if (pu_q ? push_bad : pop_bad) begin
								halted_q      <= 1'b1;
								pc_q          <= pc_q;
								res_q.next_pc <= pc_q;
								res_q.status  <= pu_q ? ST_SOVF : ST_SUNF;
							end else if (!pu_q && imm_q == 16'd0) begin
								sp_q <= sp_q - 16'd2;
							end else begin
								state_q <= pu_q ? S_PSEL : S_QSEL;
								done_q  <= 1'b0;
								pc_q    <= pc_q;
							end
						end
						OP_LOCS: begin
							if (locs_bad) begin
								halted_q      <= 1'b1;
								pc_q          <= pc_q;
								res_q.next_pc <= pc_q;
								res_q.status  <= ST_BOVF;
							end else begin
								sp_q <= sp_q + imm_q;
							end
						end
						OP_BR: begin
							if (bk_q == BK_JSR) begin
								pc_q <= pc_q;
								if (jsr_bad) begin
									halted_q      <= 1'b1;
									res_q.next_pc <= pc_q;
									res_q.status  <= ST_SOVF;
								end else begin
									wv_q       <= pc_plus2;
									wa_q       <= sp_q;
									wsel_stk_q <= 1'b1;
									state_q    <= S_WLO;
									done_q     <= 1'b0;
								end
							end else if (bk_q == BK_RET) begin
								pc_q <= pc_q;
								if (ret_bad) begin
									halted_q      <= 1'b1;
									res_q.next_pc <= pc_q;
									res_q.status  <= ST_SUNF;
								end else begin
									ra_q    <= wrap_mod(bp_q - 16'd2, STK_SZ);
									ra2_q   <= wrap_mod(bp_q - 16'd4, STK_SZ);
									state_q <= S_SRD;
									done_q  <= 1'b0;
								end
							end else if (take) begin
								pc_q          <= target;
								res_q.next_pc <= target;
							end
						end
						OP_TRAP: begin
							res_q.trap_code <= imm_q;
							res_q.trap_user <= pu_q;
							if (imm_q == TRAP_HALT) begin
								halted_q      <= 1'b1;
								pc_q          <= pc_q;
								res_q.next_pc <= pc_q;
								res_q.status  <= ST_HALT;
							end else if (imm_q == TRAP_DUMP) begin
								state_q <= S_DRQ;
								done_q  <= 1'b0;
							end
						end
						default: begin
							if (alu_setf) begin
								flags_q         <= alu_flags;
								res_q.flag_bits <= alu_flags;
							end
						end
					endcase
				end
				S_SRD: begin
					state_q <= S_SDAT;
				end
				S_DRD: begin
					state_q <= S_DDAT;
				end
				S_SDAT: begin
					case (op_q)
						OP_ST: begin
							wv_q       <= s_word;
							wa_q       <= dest_q;
							wsel_stk_q <= 1'b0;
							state_q    <= S_WLO;
						end
						OP_STACK: begin
							bit_q   <= bit_q + 4'd1;
							state_q <= S_QSEL;
						end
						OP_BR: begin
							if (!phase_q) begin
								tmp_q   <= s_word;
								ra_q    <= ra2_q;
								phase_q <= 1'b1;
								state_q <= S_SRD;
							end else begin
								bp_q          <= tmp_q;
								sp_q          <= bp_q - 16'd4;
								pc_q          <= s_word + 16'd2;
								res_q         <= ok_res;
								res_q.next_pc <= s_word + 16'd2;
								done_q        <= 1'b1;
								state_q       <= S_IDLE;
							end
						end
						default: begin
							pc_q    <= pc_plus2;
							res_q   <= ok_res;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_DDAT: begin
					pc_q    <= pc_plus2;
					res_q   <= ok_res;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_WLO: begin
					state_q <= S_WHI;
				end
				S_WHI: begin
					case (op_q)
						OP_STACK: begin
							sp_q    <= sp_q + 16'd2;
							bit_q   <= bit_q + 4'd1;
							state_q <= S_PSEL;
						end
						OP_BR: begin
							sp_q          <= sp_q + 16'd2;
							pc_q          <= target;
							res_q         <= ok_res;
							res_q.next_pc <= target;
							done_q        <= 1'b1;
							state_q       <= S_IDLE;
						end
						default: begin
							pc_q    <= pc_plus2;
							res_q   <= ok_res;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_PSEL: begin
					if (bit_q[3]) begin
						pc_q    <= pc_plus2;
						res_q   <= ok_res;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (imm_q[bit_q[2:0]]) begin
						state_q <= S_PRD;
					end else begin
						bit_q <= bit_q + 4'd1;
					end
				end
				S_PRD: begin
					wv_q       <= rf_a;
					wa_q       <= sp_q;
					wsel_stk_q <= 1'b1;
					state_q    <= S_WLO;
				end
				S_QSEL: begin
					if (bit_q[3]) begin
						pc_q    <= pc_plus2;
						res_q   <= ok_res;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (imm_q[bit_q[2:0]]) begin
						sp_q    <= sp_q - 16'd2;
						ra_q    <= wrap_mod(sp_q - 16'd2, STK_SZ);
						state_q <= S_SRD;
					end else begin
						bit_q <= bit_q + 4'd1;
					end
				end
				S_DRQ: begin
					state_q <= S_DEM;
				end
				S_DEM: begin
					res_q           <= '0;
					res_q.next_pc   <= pc_q;
					res_q.flag_bits <= flags_q;
					res_q.status    <= ST_OK;
					res_q.trap_code <= imm_q;
					res_q.trap_user <= pu_q;
					res_q.reg_index <= bit_q[2:0];
					res_q.reg_value <= rf_a;
					res_q.last      <= (bit_q[2:0] == 3'd7);
					done_q          <= 1'b1;
					bit_q           <= bit_q + 4'd1;
					state_q         <= (bit_q[2:0] == 3'd7) ? S_IDLE : S_DRQ;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// start address load
			if (cfg_wr_en) pc_q <= cfg_wr_data;
		end
	end

	// result ports
	assign done      = done_q;
	assign next_pc   = res_q.next_pc;
	assign flag_bits = res_q.flag_bits;
	assign status    = res_q.status;
	assign trap_code = res_q.trap_code;
	assign trap_user = res_q.trap_user;
	assign reg_index = res_q.reg_index;
	assign reg_value = res_q.reg_value;
	assign last      = res_q.last;

	// checks
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag dropped");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |=> !done_q)
		else $error("result during clearing pass");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status != ST_OK) |-> res_q.last)
		else $error("error result not marked last");

	a_halted_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && halted_q) |=> (done_q && res_q.status == ST_HALT))
		else $error("halted request not answered");

	a_mem_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		(dm_req.we || sm_req.we) |->
		(state_q == S_CLEAR || state_q == S_WLO || state_q == S_WHI))
		else $error("memory write outside write states");

endmodule
`default_nettype wire

### tb/register_vm_execute_unit_tb.sv
`default_nettype none
module register_vm_execute_unit_tb;
	import rvx_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE = 60;

	typedef struct packed {
		logic [3:0]  op;
		logic [1:0]  mode;
		logic [2:0]  dst;
		logic [2:0]  src;
		logic [15:0] imm;
		logic [2:0]  bk;
		logic        pu;
	} instr_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [3:0]  op = '0;
	logic [1:0]  src_mode = '0;
	logic [2:0]  dst_reg = '0;
	logic [2:0]  src_reg = '0;
	logic [15:0] imm = '0;
	logic [2:0]  branch_kind = '0;
	logic        push_or_user = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        done;
	res_t        got;

	register_vm_execute_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .src_mode(src_mode), .dst_reg(dst_reg), .src_reg(src_reg),
		.imm(imm), .branch_kind(branch_kind), .push_or_user(push_or_user),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data), .done(done),
		.next_pc(got.next_pc), .flag_bits(got.flag_bits), .status(got.status),
		.trap_code(got.trap_code), .trap_user(got.trap_user),
		.reg_index(got.reg_index), .reg_value(got.reg_value), .last(got.last)
	);

	// machine state as the instructions see it
	logic [15:0] m_reg [0:7];
	logic [3:0]  m_flags;
	logic [15:0] m_pc, m_sp, m_bp;
	logic [7:0]  m_dmem [0:65535];
	logic [7:0]  m_smem [0:65535];
	logic        m_halted;

	res_t expected_results[$];
	int unsigned mismatches = 0;
	int unsigned n_requests = 0;
	int unsigned n_results = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_results.size());
			$display("simulation failed");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			n_results <= n_results + 1;
			if (expected_results.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result: %p", got);
			end else begin
				res_t e;
				e = expected_results.pop_front();
				if (got !== e) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected %p got %p", e, got);
				end
			end
		end
	end

	function automatic logic [15:0] mem_word(input logic is_stack, input logic [15:0] a);
		logic [15:0] a1;
		a1 = a + 16'd1;
		if (is_stack)
			return {m_smem[a1], m_smem[a]};
		return {m_dmem[a1], m_dmem[a]};
	endfunction

	function automatic int unsigned mask_count(input logic [15:0] v);
		int unsigned c;
		c = 0;
		for (int i = 0; i < 8; i++)
			c += v[i];
		return c;
	endfunction

	// error status an instruction would raise, without touching state
	function automatic logic [2:0] fault_of(input instr_t it);
		int unsigned n, cnt;
		n = mask_count(it.imm);
		case (it.op)
			OP_ST, OP_LD:
				if (it.mode == MODE_BASE && int'(m_bp) + 2 * int'(it.imm) > int'(m_sp))
					return ST_ILL;
			OP_STACK:
				if (it.pu) begin
					if (n != 0 && int'(m_sp) + 2 * (n - 1) > 65533)
						return ST_SOVF;
				end else begin
					cnt = (it.imm == 0) ? 1 : n;
					if (int'(m_sp) < 2 * cnt)
						return ST_SUNF;
				end
			OP_LOCS:
				if (int'(m_sp) + int'(it.imm) > 65535)
					return ST_BOVF;
			OP_BR:
				if (it.bk == BK_JSR && m_sp > 16'd65533)
					return ST_SOVF;
				else if (it.bk == BK_RET && m_bp < 16'd4)
					return ST_SUNF;
			OP_TRAP:
				if (it.imm == TRAP_HALT)
					return ST_HALT;
			default: ;
		endcase
		return ST_OK;
	endfunction

	function automatic res_t make_res(input logic [15:0] npc, input logic [2:0] st,
			input logic [15:0] tc, input logic tu, input logic [2:0] idx,
			input logic [15:0] val, input logic lst);
		res_t r;
		r.next_pc = npc; r.flag_bits = m_flags; r.status = st; r.trap_code = tc;
		r.trap_user = tu; r.reg_index = idx; r.reg_value = val; r.last = lst;
		return r;
	endfunction

	function automatic void set_sub_flags(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] r;
		r = a - b;
		m_flags = {((a ^ b) & (a ^ r)) >> 15 != 0, a < b, r[15], r == 16'd0};
	endfunction

	// execute one instruction on the machine state, queue what it reports
	task automatic execute_instr(input instr_t it);
		logic [15:0] opnd, npc, v, a, ra;
		logic [16:0] s;
		logic [31:0] w;
		logic signed [15:0] sv;
		logic [2:0] st;
		logic take;
		if (m_halted) begin
			expected_results.push_back(make_res(m_pc, ST_HALT, 16'd0, 1'b0, 3'd0, 16'd0, 1'b1));
			return;
		end
		st = fault_of(it);
		if (st != ST_OK) begin
			m_halted = 1'b1;
			expected_results.push_back(make_res(m_pc, st, (it.op == OP_TRAP) ? it.imm : 16'd0,
				(it.op == OP_TRAP) ? it.pu : 1'b0, 3'd0, 16'd0, 1'b1));
			return;
		end
		opnd = (it.mode == MODE_REG) ? m_reg[it.src] : it.imm;
		npc = m_pc + 16'd2;
		ra = m_reg[it.dst];
		case (it.op)
			OP_ADD: begin
				s = {1'b0, ra} + {1'b0, opnd};
				m_flags = {((~(ra ^ opnd) & (ra ^ s[15:0])) >> 15) != 0, s[16], s[15],
					s[15:0] == 16'd0};
				m_reg[it.dst] = s[15:0];
			end
			OP_SUB: begin
				set_sub_flags(ra, opnd);
				m_reg[it.dst] = ra - opnd;
			end
			OP_CMP: set_sub_flags(ra, opnd);
			OP_SHL: begin
				w = (it.imm > 16'd16) ? 32'd0 : ({16'd0, ra} << it.imm);
				m_flags = {1'b0, w[16], w[15], w[15:0] == 16'd0};
				m_reg[it.dst] = w[15:0];
			end
			OP_ASHR: begin
				sv = ra;
				m_reg[it.dst] = (it.imm >= 16'd16) ? {16{ra[15]}} : 16'(sv >>> it.imm);
			end
			OP_LSHR: m_reg[it.dst] = (it.imm >= 16'd16) ? 16'd0 : ra >> it.imm;
			OP_AND:  m_reg[it.dst] = ra & opnd;
			OP_OR:   m_reg[it.dst] = ra | opnd;
			OP_NOT:  m_reg[it.dst] = ~ra;
			OP_ST: begin
				if (it.mode == MODE_IMM) v = it.imm;
				else if (it.mode == MODE_BASE) v = mem_word(1'b1, m_bp + (it.imm << 1));
				else v = m_reg[it.src];
				m_dmem[ra] = v[7:0];
				m_dmem[ra + 16'd1] = v[15:8];
			end
			OP_LD: begin
				if (it.mode == MODE_REG) v = m_reg[it.src];
				else if (it.mode == MODE_IMM) v = it.imm;
				else if (it.mode == MODE_BASE) v = mem_word(1'b1, m_bp + (it.imm << 1));
				else v = mem_word(1'b0, m_reg[it.src]);
				m_reg[it.dst] = v;
			end
			OP_STACK: begin
				if (it.pu) begin
					for (int i = 0; i < 8; i++)
						if (it.imm[i]) begin
							m_smem[m_sp] = m_reg[i][7:0];
							m_smem[m_sp + 16'd1] = m_reg[i][15:8];
							m_sp = m_sp + 16'd2;
						end
				end else begin
					if (it.imm == 16'd0) m_sp = m_sp - 16'd2;
					for (int i = 0; i < 8; i++)
						if (it.imm[i]) begin
							m_sp = m_sp - 16'd2;
							m_reg[i] = mem_word(1'b1, m_sp);
						end
				end
			end
			OP_LOCS: m_sp = m_sp + it.imm;
			OP_BR: begin
				take = 1'b0;
				case (it.bk)
					BK_JMP: take = 1'b1;
					BK_JEQ: take = m_flags[0];
					BK_JGT: take = !m_flags[0] && (m_flags[1] == m_flags[3]);
					BK_JLT: take = m_flags[1] != m_flags[3];
					BK_JGE: take = m_flags[1] == m_flags[3];
					BK_JLE: take = m_flags[0] || (m_flags[1] != m_flags[3]);
					BK_JSR: begin
						m_smem[m_sp] = npc[7:0];
						m_smem[m_sp + 16'd1] = npc[15:8];
						m_sp = m_sp + 16'd2;
						take = 1'b1;
					end
					default: begin
						a = m_bp;
						m_bp = mem_word(1'b1, a - 16'd2);
						npc = mem_word(1'b1, a - 16'd4) + 16'd2;
						m_sp = a - 16'd4;
					end
				endcase
				if (take) npc = m_pc + (it.imm << 1);
			end
			default: ;
		endcase
		m_pc = npc;
		if (it.op == OP_TRAP && it.imm == TRAP_DUMP) begin
			for (int i = 0; i < 8; i++)
				expected_results.push_back(make_res(npc, ST_OK, it.imm, it.pu, 3'(i), m_reg[i],
					i == 7));
		end else begin
			expected_results.push_back(make_res(npc, ST_OK, (it.op == OP_TRAP) ? it.imm : 16'd0,
				(it.op == OP_TRAP) ? it.pu : 1'b0, 3'd0, 16'd0, 1'b1));
		end
	endtask

	function automatic instr_t mk(input logic [3:0] o, input logic [1:0] md,
			input logic [2:0] d, input logic [2:0] s, input logic [15:0] iv,
			input logic [2:0] b, input logic p);
		instr_t it;
		it.op = o; it.mode = md; it.dst = d; it.src = s; it.imm = iv; it.bk = b; it.pu = p;
		return it;
	endfunction

	// send one request, then drop start for a random gap between bursts of random length
	task automatic send_request(input instr_t it);
		int unsigned gap;
		@(negedge clk);
		start <= 1'b1;
		op <= it.op; src_mode <= it.mode; dst_reg <= it.dst; src_reg <= it.src;
		imm <= it.imm; branch_kind <= it.bk; push_or_user <= it.pu;
		@(posedge clk);
		while (busy) @(posedge clk);
		execute_instr(it);
		n_requests++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
		end else begin
			burst_left--;
			gap = 0;
		end
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// hold off until every expected result has come and the unit has settled
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_start(input logic [15:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		m_pc = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_alu();
		send_request(mk(OP_LD, MODE_IMM, 3'd1, 3'd0, 16'hFFFF, BK_JMP, 1'b0));
		send_request(mk(OP_ADD, MODE_IMM, 3'd1, 3'd0, 16'h0001, BK_JMP, 1'b0));
		send_request(mk(OP_LD, MODE_IMM, 3'd2, 3'd0, 16'h7FFF, BK_JMP, 1'b0));
		send_request(mk(OP_ADD, MODE_IMM, 3'd2, 3'd0, 16'h0001, BK_JMP, 1'b0));
		send_request(mk(OP_SUB, MODE_REG, 3'd1, 3'd2, 16'h0000, BK_JMP, 1'b0));
		send_request(mk(OP_SHL, MODE_IMM, 3'd2, 3'd0, 16'd16, BK_JMP, 1'b0));
		send_request(mk(OP_LD, MODE_IMM, 3'd3, 3'd0, 16'h8421, BK_JMP, 1'b0));
		send_request(mk(OP_ASHR, MODE_IMM, 3'd3, 3'd0, 16'd20, BK_JMP, 1'b0));
		send_request(mk(OP_LSHR, MODE_IMM, 3'd3, 3'd0, 16'd16, BK_JMP, 1'b0));
		send_request(mk(OP_NOT, MODE_REG, 3'd4, 3'd0, 16'h0000, BK_JMP, 1'b0));
		send_request(mk(OP_AND, MODE_IMM, 3'd4, 3'd0, 16'h0FF0, BK_JMP, 1'b0));
		send_request(mk(OP_OR, MODE_REG, 3'd4, 3'd3, 16'h0000, BK_JMP, 1'b0));
		send_request(mk(OP_CMP, MODE_IMM, 3'd4, 3'd0, 16'hFFFF, BK_JMP, 1'b0));
		send_request(mk(4'hF, MODE_IND, 3'd7, 3'd7, 16'hFFFF, BK_RET, 1'b1));
	endtask

	task automatic test_memory_stack();
		send_request(mk(OP_ST, MODE_IMM, 3'd4, 3'd0, 16'hBEEF, BK_JMP, 1'b0));
		send_request(mk(OP_LD, MODE_IND, 3'd5, 3'd4, 16'h0000, BK_JMP, 1'b0));
		send_request(mk(OP_STACK, MODE_REG, 3'd0, 3'd0, 16'hFFFF, BK_JMP, 1'b1));
		send_request(mk(OP_STACK, MODE_REG, 3'd0, 3'd0, 16'h0000, BK_JMP, 1'b0));
		send_request(mk(OP_ST, MODE_BASE, 3'd5, 3'd0, 16'd3, BK_JMP, 1'b0));
		send_request(mk(OP_LD, MODE_BASE, 3'd6, 3'd0, 16'd7, BK_JMP, 1'b0));
		send_request(mk(OP_STACK, MODE_REG, 3'd0, 3'd0, 16'h00A5, BK_JMP, 1'b0));
		send_request(mk(OP_LOCS, MODE_REG, 3'd0, 3'd0, 16'd10, BK_JMP, 1'b0));
	endtask

	task automatic test_branch_trap();
		for (int k = 0; k < 7; k++)
			send_request(mk(OP_BR, 2'($urandom), 3'($urandom), 3'($urandom),
				(k == 0) ? 16'h8000 : 16'($urandom), 3'(k), 1'($urandom)));
		send_request(mk(OP_TRAP, MODE_REG, 3'd0, 3'd0, TRAP_DUMP, BK_JMP, 1'b1));
		send_request(mk(OP_TRAP, MODE_REG, 3'd0, 3'd0, 16'h1234, BK_JMP, 1'b0));
	endtask

	// mostly error-free instructions so the machine keeps running
	function automatic instr_t random_instr();
		instr_t it;
		it = instr_t'({$urandom, $urandom});
		case (it.op)
			OP_SHL, OP_ASHR, OP_LSHR:
				if ($urandom_range(0, 3) != 0) it.imm = $urandom_range(0, 20);
			OP_LOCS: it.imm = $urandom_range(0, 40);
			OP_ST, OP_LD:
				if (it.mode == MODE_BASE) it.imm = $urandom_range(0, 12);
			OP_TRAP:
				if ($urandom_range(0, 2) == 0) it.imm = TRAP_DUMP;
			default: ;
		endcase
		return it;
	endfunction

	task automatic test_random(input int unsigned count);
		instr_t it;
		for (int unsigned k = 0; k < count; k++) begin
			it = random_instr();
			while (fault_of(it) != ST_OK) it = random_instr();
			send_request(it);
			if (k == count / 2) begin
				wait_idle();
				write_start(16'($urandom));
			end
		end
	endtask

	// one error per run halts the machine for good, then it only reports halt
	task automatic test_halt();
		instr_t it;
		case ($urandom_range(0, 6))
			0: it = mk(OP_TRAP, MODE_REG, 3'd0, 3'd0, TRAP_HALT, BK_JMP, 1'($urandom));
			1: it = mk(OP_STACK, MODE_REG, 3'd0, 3'd0, 16'h0001, BK_JMP, 1'b1);
			2: it = mk(OP_BR, MODE_REG, 3'd0, 3'd0, 16'h0004, BK_JSR, 1'b0);
			3: it = mk(OP_LOCS, MODE_REG, 3'd0, 3'd0, 16'h0001, BK_JMP, 1'b0);
			4: it = mk(OP_BR, MODE_REG, 3'd0, 3'd0, 16'h0000, BK_RET, 1'b0);
			5: it = mk(OP_LD, MODE_BASE, 3'd1, 3'd0, 16'hFFFF, BK_JMP, 1'b0);
			default: it = mk(OP_STACK, MODE_REG, 3'd0, 3'd0, 16'h00FF, BK_JMP, 1'b0);
		endcase
		// stack full first so overflow cases bite, or empty for underflow
		if (it.op == OP_STACK && !it.pu) begin
			while (m_sp >= 16'd16)
				send_request(mk(OP_STACK, MODE_REG, 3'd0, 3'd0, 16'h00FF, BK_JMP, 1'b0));
			if (m_sp != 0)
				send_request(mk(OP_STACK, MODE_REG, 3'd0, 3'd0, 16'h0100, BK_JMP, 1'b0));
		end else if (it.op != OP_TRAP && it.op != OP_LD && it.bk != BK_RET) begin
			send_request(mk(OP_LOCS, MODE_REG, 3'd0, 3'd0, 16'hFFFF - m_sp, BK_JMP, 1'b0));
		end
		send_request(it);
		for (int k = 0; k < 6; k++)
			send_request(instr_t'({$urandom, $urandom}));
	endtask

	initial begin
		for (int i = 0; i < 8; i++) m_reg[i] = 16'd0;
		for (int i = 0; i < 65536; i++) begin
			m_dmem[i] = 8'd0;
			m_smem[i] = 8'd0;
		end
		m_flags = 4'd0; m_pc = 16'd0; m_sp = 16'd0; m_bp = 16'd0; m_halted = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_start(16'hFFFF);
		test_alu();
		test_memory_stack();
		test_branch_trap();
		wait_idle();
		write_start(16'h0000);
		test_random(130);
		wait_idle();
		write_start(16'hFFFE);
		test_halt();
		wait_idle();
		if (expected_results.size() != 0) mismatches++;
		$display("%0d requests sent, %0d results checked, %0d mismatches", n_requests,
			n_results, mismatches);
		$display("covered alu, memory, stack, branches, dump trap and a halting error");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
